### hw/rtl/ias_pkg.sv
// ias_pkg: shared types and constants for the 128-bit arithmetic pipeline
// no dependencies
package ias_pkg;

    localparam int unsigned WIDTH_MAX = 128;
    localparam int unsigned WIDTH_DEF = 128;
    localparam int unsigned HALF_W    = 64;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]        operation;
        logic [HALF_W-1:0] a_hi;
        logic [HALF_W-1:0] a_lo;
        logic [HALF_W-1:0] b_hi;
        logic [HALF_W-1:0] b_lo;
    } t_in;

    typedef struct packed {
        logic [HALF_W-1:0] result_hi;
        logic [HALF_W-1:0] result_lo;
    } t_out;

endpackage

### hw/rtl/int128_add_sub_mul_div.sv
// int128_add_sub_mul_div: pipelined 128-bit add, subtract, multiply, divide
// depends on ias_pkg and ias_stage
//
//  channel | valid   | ready   | payload
//  in      | i_valid | o_ready | i_data (ias_pkg::t_in)
//  out     | o_valid | i_ready | o_data (ias_pkg::t_out)
//
// every operation passes through one prep stage, WIDTH bit
// stages (one multiplier bit and one divider bit each), one output stage
// one transaction per cycle; the whole pipe advances together when the
// output register is empty or being taken
// reset clears only the valid bits; a stall holds every stage in place
module int128_add_sub_mul_div #(
    parameter int unsigned WIDTH = ias_pkg::WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ias_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output ias_pkg::t_out o_data
);
    localparam int unsigned MW = ias_pkg::WIDTH_MAX;

    logic w_en;
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    // prep stage: trim, add/sub result, divide magnitudes
    logic [MW-1:0]    w_ain, w_bin;
    logic [WIDTH-1:0] w_a, w_b, w_ma, w_mb, n_acc;
    logic             w_sa, w_sb, w_bz;
    always_comb begin
        w_ain = {i_data.a_hi, i_data.a_lo};
        w_bin = {i_data.b_hi, i_data.b_lo};
        w_a   = w_ain[WIDTH-1:0];
        w_b   = w_bin[WIDTH-1:0];
        w_sa  = w_a[WIDTH-1];
        w_sb  = w_b[WIDTH-1];
        w_ma  = w_sa ? -w_a : w_a;
        w_mb  = w_sb ? -w_b : w_b;
        w_bz  = (w_b == '0);
        unique case (i_data.operation)
            ias_pkg::OP_ADD: n_acc = w_a + w_b;
            ias_pkg::OP_SUB: n_acc = w_a - w_b;
            default:         n_acc = '0;
        endcase
    end

    logic             r_pv;
    logic [1:0]       r_pop;
    logic [WIDTH-1:0] r_pa, r_pb, r_pacc;
    logic             r_pneg, r_pz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (w_en) begin
            r_pv <= i_valid;
        end
        if (w_en) begin
            r_pop  <= i_data.operation;
            r_pacc <= n_acc;
            r_pz   <= w_bz;
            if (i_data.operation == ias_pkg::OP_DIV) begin
                r_pa   <= w_ma;
                r_pb   <= w_mb;
                r_pneg <= w_sa ^ w_sb;
            end else begin
                r_pa   <= w_a;
                r_pb   <= w_b;
                r_pneg <= 1'b0;
            end
        end
    end

    // bit stages; sign rides in the neg lane, zero-divisor flag in a separate delay line
    logic             s_v   [WIDTH+1];
    logic [1:0]       s_op  [WIDTH+1];
    logic [WIDTH-1:0] s_a   [WIDTH+1];
    logic [WIDTH-1:0] s_b   [WIDTH+1];
    logic [WIDTH-1:0] s_acc [WIDTH+1];
    logic [WIDTH-1:0] s_rem [WIDTH+1];
    logic             s_neg [WIDTH+1];
    logic [WIDTH-1:0] r_zline;

    assign s_v[0]   = r_pv;
    assign s_op[0]  = r_pop;
    assign s_a[0]   = r_pa;
    assign s_b[0]   = r_pb;
    assign s_acc[0] = r_pacc;
    assign s_rem[0] = '0;
    assign s_neg[0] = r_pneg;

    for (genvar g = 0; g < WIDTH; g++) begin : g_stage
        ias_stage #(.WIDTH(WIDTH), .IDX(g)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (s_v[g]),
            .i_op    (s_op[g]),
            .i_a     (s_a[g]),
            .i_b     (s_b[g]),
            .i_acc   (s_acc[g]),
            .i_rem   (s_rem[g]),
            .i_neg   (s_neg[g]),
            .o_valid (s_v[g+1]),
            .o_op    (s_op[g+1]),
            .o_a     (s_a[g+1]),
            .o_b     (s_b[g+1]),
            .o_acc   (s_acc[g+1]),
            .o_rem   (s_rem[g+1]),
            .o_neg   (s_neg[g+1])
        );
    end

    // zero-divisor flag delay line alongside the bit stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zline <= {r_zline[WIDTH-2:0], r_pz};
        end
    end

    // output stage: sign fix and zero-divisor override
    logic [WIDTH-1:0] n_res;
    logic [MW-1:0]    w_res;
    logic             r_ov;
    ias_pkg::t_out    r_od;
    always_comb begin
        n_res = s_acc[WIDTH];
        if (s_op[WIDTH] == ias_pkg::OP_DIV) begin
            if (r_zline[WIDTH-1]) begin
                n_res = '1;
            end else if (s_neg[WIDTH]) begin
                n_res = -s_acc[WIDTH];
            end
        end
        w_res = MW'(n_res);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= s_v[WIDTH];
        end
        if (w_en) begin
            r_od.result_hi <= w_res[MW-1:ias_pkg::HALF_W];
            r_od.result_lo <= w_res[ias_pkg::HALF_W-1:0];
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_od;
endmodule

### hw/rtl/ias_stage.sv
// ias_stage: one pipeline step doing one multiplier bit and one divider bit
// depends on ias_pkg
module ias_stage #(
    parameter int unsigned WIDTH = ias_pkg::WIDTH_DEF,
    parameter int unsigned IDX   = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [1:0]       i_op,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic [WIDTH-1:0] i_acc,
    input  logic [WIDTH-1:0] i_rem,
    input  logic             i_neg,
    output logic             o_valid,
    output logic [1:0]       o_op,
    output logic [WIDTH-1:0] o_a,
    output logic [WIDTH-1:0] o_b,
    output logic [WIDTH-1:0] o_acc,
    output logic [WIDTH-1:0] o_rem,
    output logic             o_neg
);
    // multiply: acc += b[IDX] ? a<<IDX ; divide: restoring step on bit WIDTH-1-IDX
    localparam int unsigned DBIT = WIDTH - 1 - IDX;
    logic [WIDTH-1:0] n_acc, n_rem, w_sh;
    logic [WIDTH:0]   w_diff;
    logic             r_valid;
    logic [1:0]       r_op;
    logic [WIDTH-1:0] r_a, r_b, r_acc, r_rem;
    logic             r_neg;

    always_comb begin
        n_acc  = i_acc;
        n_rem  = i_rem;
        w_sh   = {i_rem[WIDTH-2:0], i_a[DBIT]};
        w_diff = {1'b0, w_sh} - {1'b0, i_b};
        if (i_op == ias_pkg::OP_DIV) begin
            // top remainder bit shifted out means rem >= 2^(WIDTH-1) >= b
            if (i_rem[WIDTH-1] || !w_diff[WIDTH]) begin
                n_rem        = w_diff[WIDTH-1:0];
                n_acc[DBIT]  = 1'b1;
            end else begin
                n_rem = w_sh;
            end
        end else if (i_op == ias_pkg::OP_MUL && i_b[IDX]) begin
            n_acc = i_acc + (i_a << IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_op  <= i_op;
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= n_acc;
            r_rem <= n_rem;
            r_neg <= i_neg;
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_acc   = r_acc;
    assign o_rem   = r_rem;
    assign o_neg   = r_neg;
endmodule

### hw/rtl/ias_checker.sv
// ias_checker: port-level assertions for int128_add_sub_mul_div
// depends on ias_pkg; bound to the top level below
module ias_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_ready,
    input logic          o_valid,
    input logic          i_ready,
    input ias_pkg::t_out o_data
);
    // ready only drops while output holds a transaction
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready) else $error("ready low with empty output");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    // nothing comes out in the first cycle after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("output valid after reset");
endmodule

bind int128_add_sub_mul_div ias_checker u_ias_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
